@@ rtl/ryp_pkg.sv @@
// Shared types and constants of the RGB to planar YUV 4:2:0 converter.
package ryp_pkg;

    // Field widths.
    localparam int COMP_W   = 8;
    localparam int CFG_W    = 13;
    localparam int LUMA_W   = 24;
    localparam int OFF_W    = 25;
    localparam int PLANE_W  = 2;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 40;
    localparam int CFG_INDEX_W = 4;

    // Register indexes of the configuration port.
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 4'd1;

    // Register reset values.
    localparam logic [CFG_W-1:0] RESET_FRAME_WIDTH  = 13'd1920;
    localparam logic [CFG_W-1:0] RESET_FRAME_HEIGHT = 13'd1080;

    // Plane codes carried on the result channel.
    localparam logic [PLANE_W-1:0] PLANE_LUMA = 2'd0;
    localparam logic [PLANE_W-1:0] PLANE_CB   = 2'd1;
    localparam logic [PLANE_W-1:0] PLANE_CR   = 2'd2;

    // BT.601 integer coefficients, held at the width of the dot products.
    localparam int PROD_W    = 18;
    localparam int FRAC_BITS = 8;
    localparam logic signed [PROD_W-1:0] Y_R   = 18'sd66;
    localparam logic signed [PROD_W-1:0] Y_G   = 18'sd129;
    localparam logic signed [PROD_W-1:0] Y_B   = 18'sd25;
    localparam logic signed [PROD_W-1:0] Y_OFS = 18'sd16;
    localparam logic signed [PROD_W-1:0] CB_R  = -18'sd38;
    localparam logic signed [PROD_W-1:0] CB_G  = -18'sd74;
    localparam logic signed [PROD_W-1:0] CB_B  = 18'sd112;
    localparam logic signed [PROD_W-1:0] CR_R  = 18'sd112;
    localparam logic signed [PROD_W-1:0] CR_G  = -18'sd94;
    localparam logic signed [PROD_W-1:0] CR_B  = -18'sd18;
    localparam logic signed [PROD_W-1:0] C_OFS = 18'sd128;

    // Queue between the front and the back.
    localparam int QDEPTH   = 4;
    localparam int QADDR_W  = 2;
    localparam int QCOUNT_W = 3;
    localparam logic [QCOUNT_W-1:0] QFULL = 3'd4;

    // One classified pixel with its converted samples and destination offsets.
    typedef struct packed {
        logic              chroma;
        logic [LUMA_W-1:0] luma_off;
        logic [OFF_W-1:0]  cb_off;
        logic [OFF_W-1:0]  cr_off;
        logic [COMP_W-1:0] y_val;
        logic [COMP_W-1:0] cb_val;
        logic [COMP_W-1:0] cr_val;
    } entry_t;

endpackage

@@ rtl/ryp_front.sv @@
// Front end: configuration, raster counters, color conversion and queue push.
module ryp_front #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [ryp_pkg::S_TDATA_W-1:0]       s_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ryp_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [ryp_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                q_full,
    output logic                                q_push,
    output ryp_pkg::entry_t                     q_entry
);

    localparam int CFGX_W  = ryp_pkg::CFG_W + 1;
    localparam int EW_W    = $clog2(MAX_WIDTH + 1);
    localparam int EH_W    = $clog2(MAX_HEIGHT + 1);
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int AREA_W  = EW_W + EH_W;
    localparam int AREA1_W = AREA_W + 1;
    localparam int OW      = ryp_pkg::OFF_W;
    localparam int LW      = ryp_pkg::LUMA_W;
    localparam int PW      = ryp_pkg::PROD_W;
    localparam int CW      = ryp_pkg::COMP_W;
    localparam logic [CFGX_W-1:0] MAX_W_X = CFGX_W'(MAX_WIDTH);
    localparam logic [CFGX_W-1:0] MAX_H_X = CFGX_W'(MAX_HEIGHT);
    localparam logic [CFGX_W-1:0] MIN_X   = CFGX_W'(2);

    // Width clamped to the supported range and forced even.
    function automatic logic [EW_W-1:0] clamp_width(input logic [ryp_pkg::CFG_W-1:0] v);
        logic [CFGX_W-1:0] vx;
        vx = {1'b0, v};
        if (vx < MIN_X) begin
            vx = MIN_X;
        end else if (vx > MAX_W_X) begin
            vx = MAX_W_X;
        end
        vx = vx & ~CFGX_W'(1);
        return EW_W'(vx);
    endfunction

    // Height clamped to the supported range.
    function automatic logic [EH_W-1:0] clamp_height(input logic [ryp_pkg::CFG_W-1:0] v);
        logic [CFGX_W-1:0] vx;
        vx = {1'b0, v};
        if (vx < MIN_X) begin
            vx = MIN_X;
        end else if (vx > MAX_H_X) begin
            vx = MAX_H_X;
        end
        return EH_W'(vx);
    endfunction

    logic [EW_W-1:0]               eff_w_reg;
    logic [EH_W-1:0]               eff_h_reg;
    logic                          pending_reg;
    logic [COL_W-1:0]              col_reg;
    logic [ROW_W-1:0]              row_reg;
    logic [ryp_pkg::LUMA_W-1:0]    luma_ptr_reg;
    logic [OW-1:0]                 cb_ptr_reg;
    logic [OW-1:0]                 cr_ptr_reg;
    logic [OW-1:0]                 cb_start_reg;
    logic [OW-1:0]                 cr_start_reg;

    logic [AREA_W-1:0]             area;
    logic [AREA1_W-1:0]            cr_full;
    logic [EW_W-1:0]               col_inc;
    logic [EH_W-1:0]               row_inc;
    logic                          chroma;
    logic                          cfg_write;

    logic [CW-1:0]                 s_red;
    logic [CW-1:0]                 s_green;
    logic [CW-1:0]                 s_blue;
    logic signed [PW-1:0]          r_s;
    logic signed [PW-1:0]          g_s;
    logic signed [PW-1:0]          b_s;
    logic signed [PW-1:0]          y_sum;
    logic signed [PW-1:0]          cb_sum;
    logic signed [PW-1:0]          cr_sum;

    // Pixels wait while the chroma base offsets are being recomputed or the queue is full.
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign s_tready  = !pending_reg && !q_full;
    assign q_push    = s_tvalid && s_tready;

    // Plane sizes for the chroma base offsets.
    assign area    = AREA_W'(eff_w_reg) * AREA_W'(eff_h_reg);
    assign cr_full = AREA1_W'(area) + AREA1_W'(area >> 2);

    // Raster position bookkeeping.
    assign col_inc = EW_W'(col_reg) + EW_W'(1);
    assign row_inc = EH_W'(row_reg) + EH_W'(1);
    assign chroma  = !row_reg[0] && !col_reg[0];

    // Unpack the pixel and form the three dot products.
    assign s_red   = s_tdata[7:0];
    assign s_green = s_tdata[15:8];
    assign s_blue  = s_tdata[23:16];
    assign r_s     = $signed({{(PW-CW){1'b0}}, s_red});
    assign g_s     = $signed({{(PW-CW){1'b0}}, s_green});
    assign b_s     = $signed({{(PW-CW){1'b0}}, s_blue});
    assign y_sum   = ryp_pkg::Y_R * r_s + ryp_pkg::Y_G * g_s + ryp_pkg::Y_B * b_s;
    assign cb_sum  = ryp_pkg::CB_R * r_s + ryp_pkg::CB_G * g_s + ryp_pkg::CB_B * b_s;
    assign cr_sum  = ryp_pkg::CR_R * r_s + ryp_pkg::CR_G * g_s + ryp_pkg::CR_B * b_s;

    // Queue entry: samples after the floor shift and offset, plus destinations.
    always_comb begin
        q_entry.chroma   = chroma;
        q_entry.luma_off = luma_ptr_reg;
        q_entry.cb_off   = cb_ptr_reg;
        q_entry.cr_off   = cr_ptr_reg;
        q_entry.y_val    = CW'((y_sum >>> ryp_pkg::FRAC_BITS) + ryp_pkg::Y_OFS);
        q_entry.cb_val   = CW'((cb_sum >>> ryp_pkg::FRAC_BITS) + ryp_pkg::C_OFS);
        q_entry.cr_val   = CW'((cr_sum >>> ryp_pkg::FRAC_BITS) + ryp_pkg::C_OFS);
    end

    // Configuration registers and frame restart.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eff_w_reg   <= clamp_width(ryp_pkg::RESET_FRAME_WIDTH);
            eff_h_reg   <= clamp_height(ryp_pkg::RESET_FRAME_HEIGHT);
            pending_reg <= 1'b1;
        end else if (cfg_write) begin
            if (cfg_index == ryp_pkg::REG_FRAME_WIDTH) begin
                eff_w_reg   <= clamp_width(cfg_data);
                pending_reg <= 1'b1;
            end else if (cfg_index == ryp_pkg::REG_FRAME_HEIGHT) begin
                eff_h_reg   <= clamp_height(cfg_data);
                pending_reg <= 1'b1;
            end
        end else begin
            pending_reg <= 1'b0;
        end
    end

    // Raster counters and destination pointers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            luma_ptr_reg <= '0;
            cb_ptr_reg   <= '0;
            cr_ptr_reg   <= '0;
            cb_start_reg <= '0;
            cr_start_reg <= '0;
        end else if (pending_reg) begin
            col_reg      <= '0;
            row_reg      <= '0;
            luma_ptr_reg <= '0;
            cb_start_reg <= OW'(area);
            cr_start_reg <= OW'(cr_full);
            cb_ptr_reg   <= OW'(area);
            cr_ptr_reg   <= OW'(cr_full);
        end else if (q_push) begin
            luma_ptr_reg <= luma_ptr_reg + LW'(1);
            if (chroma) begin
                cb_ptr_reg <= cb_ptr_reg + OW'(1);
                cr_ptr_reg <= cr_ptr_reg + OW'(1);
            end
            if (col_inc >= eff_w_reg) begin
                col_reg <= '0;
                if (row_inc >= eff_h_reg) begin
                    // End of frame: start over at the top of the planes.
                    row_reg      <= '0;
                    luma_ptr_reg <= '0;
                    cb_ptr_reg   <= cb_start_reg;
                    cr_ptr_reg   <= cr_start_reg;
                end else begin
                    row_reg <= ROW_W'(row_inc);
                end
            end else begin
                col_reg <= COL_W'(col_inc);
            end
        end
    end

`ifndef ASSERT_OFF
    // No pixel is taken while the base offsets are stale.
    a_no_accept_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg |-> !s_tready)
        else $error("pixel accepted during frame restart");
`endif

endmodule

@@ rtl/ryp_queue.sv @@
// Short queue of classified pixels between the front end and the result sequencer.
module ryp_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  ryp_pkg::entry_t push_entry,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output ryp_pkg::entry_t head_entry
);

    localparam int AW = ryp_pkg::QADDR_W;
    localparam int NW = ryp_pkg::QCOUNT_W;

    ryp_pkg::entry_t                  slot_reg [ryp_pkg::QDEPTH];
    logic [ryp_pkg::QADDR_W-1:0]      wr_ptr_reg;
    logic [ryp_pkg::QADDR_W-1:0]      rd_ptr_reg;
    logic [ryp_pkg::QCOUNT_W-1:0]     count_reg;

    assign full       = (count_reg == ryp_pkg::QFULL);
    assign head_valid = (count_reg != '0);
    assign head_entry = slot_reg[rd_ptr_reg];

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + AW'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + NW'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - NW'(1);
            end
        end
    end

`ifndef ASSERT_OFF
    // The front never pushes into a full queue.
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("queue overflow");

    // The back never pops an empty queue.
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head_valid)
        else $error("queue underflow");
`endif

endmodule

@@ rtl/ryp_back.sv @@
// Back end: turns each queued pixel into one or three results through an output register.
module ryp_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            q_valid,
    input  ryp_pkg::entry_t                 q_entry,
    output logic                            q_pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ryp_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic [ryp_pkg::PLANE_W-1:0]     m_tuser,
    output logic                            m_tlast
);

    localparam logic [1:0] STEP_LUMA = 2'd0;
    localparam logic [1:0] STEP_CB   = 2'd1;
    localparam logic [1:0] STEP_CR   = 2'd2;
    localparam int PAD_W = ryp_pkg::M_TDATA_W - ryp_pkg::OFF_W - ryp_pkg::COMP_W;

    logic [1:0]                     step_reg, step_next;
    logic                           valid_reg, valid_next;
    logic [ryp_pkg::PLANE_W-1:0]    plane_reg, plane_next;
    logic [ryp_pkg::OFF_W-1:0]      off_reg, off_next;
    logic [ryp_pkg::COMP_W-1:0]     sample_reg, sample_next;
    logic                           last_reg, last_next;
    logic                           load;

    // A new result enters when the output register is empty or being drained.
    assign load = q_valid && (!valid_reg || m_tready);

    // Result sequencer: luma, then Cb and Cr for chroma pixels.
    always_comb begin
        step_next   = step_reg;
        valid_next  = valid_reg && !m_tready;
        plane_next  = plane_reg;
        off_next    = off_reg;
        sample_next = sample_reg;
        last_next   = last_reg;
        q_pop       = 1'b0;
        if (load) begin
            case (step_reg)
                STEP_LUMA: begin
                    valid_next  = 1'b1;
                    plane_next  = ryp_pkg::PLANE_LUMA;
                    off_next    = {1'b0, q_entry.luma_off};
                    sample_next = q_entry.y_val;
                    last_next   = !q_entry.chroma;
                    if (q_entry.chroma) begin
                        step_next = STEP_CB;
                    end else begin
                        q_pop = 1'b1;
                    end
                end
                STEP_CB: begin
                    valid_next  = 1'b1;
                    plane_next  = ryp_pkg::PLANE_CB;
                    off_next    = q_entry.cb_off;
                    sample_next = q_entry.cb_val;
                    last_next   = 1'b0;
                    step_next   = STEP_CR;
                end
                STEP_CR: begin
                    valid_next  = 1'b1;
                    plane_next  = ryp_pkg::PLANE_CR;
                    off_next    = q_entry.cr_off;
                    sample_next = q_entry.cr_val;
                    last_next   = 1'b1;
                    step_next   = STEP_LUMA;
                    q_pop       = 1'b1;
                end
                default: begin
                    step_next = STEP_LUMA;
                end
            endcase
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg  <= STEP_LUMA;
            valid_reg <= 1'b0;
        end else begin
            step_reg  <= step_next;
            valid_reg <= valid_next;
        end
    end

    // Output payload.
    always_ff @(posedge aclk) begin
        plane_reg  <= plane_next;
        off_reg    <= off_next;
        sample_reg <= sample_next;
        last_reg   <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = plane_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, sample_reg, off_reg};

`ifndef ASSERT_OFF
    // A pixel in the middle of its results stays at the head of the queue.
    a_head_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_reg != STEP_LUMA) |-> q_valid)
        else $error("queue head lost during chroma results");

    // Cr always closes a pixel.
    a_cr_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == ryp_pkg::PLANE_CR)) |-> m_tlast)
        else $error("Cr result not marked last");

    // Cb is never the final result of a pixel.
    a_cb_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == ryp_pkg::PLANE_CB)) |-> !m_tlast)
        else $error("Cb result marked last");
`endif

endmodule

@@ rtl/rgb_to_yuv420_planar_top.sv @@
// Top level of the streaming RGB to planar YUV 4:2:0 converter.
//
// Each accepted RGB pixel yields a luma sample at its raster offset; pixels on even rows
// and even columns also yield Cb and Cr samples at the next places of the chroma planes,
// which start after the luma plane and after the quarter-size Cb plane. Results leave
// one per cycle from an output register while m_tready is high; a luma-only pixel
// yields one result and a chroma pixel three. A four-entry queue lets pixels enter while
// earlier ones are still being emitted. After reset and after every write to the frame
// width or height register the input stalls while the multiplier computes the chroma
// base offsets from the frame size.
module rgb_to_yuv420_planar_top #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // s_tdata: red [7:0], green [15:8], blue [23:16].
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ryp_pkg::S_TDATA_W-1:0]   s_tdata,
    // m_tdata: buffer_offset [24:0], sample [32:25], zero pad [39:33].
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ryp_pkg::M_TDATA_W-1:0]   m_tdata,
    // m_tuser: plane [1:0].
    output logic [ryp_pkg::PLANE_W-1:0]     m_tuser,
    output logic                            m_tlast,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ryp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ryp_pkg::CFG_W-1:0]       cfg_data
);

    logic            q_full;
    logic            q_push;
    logic            q_pop;
    logic            q_valid;
    ryp_pkg::entry_t push_entry;
    ryp_pkg::entry_t head_entry;

    ryp_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (push_entry)
    );

    ryp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_entry (head_entry)
    );

    ryp_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_entry  (head_entry),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
